@@ hdl/dcors_pkg.sv @@
// Shared types, widths and constants of the density cut-off range scan.
`default_nettype none
package dcors_pkg;

    localparam int HEIGHT_W   = 16;
    localparam int BINW_W     = 11;
    localparam int YEAR_W     = 17;
    localparam int SCALE_W    = 32;
    localparam int POS_W      = 32;
    localparam int AREA_W     = 48;
    localparam int SHARE_W    = 16;
    localparam int MAX_BINS   = 65536;
    localparam int IDX_W      = $clog2(MAX_BINS) + 1;
    localparam int WQ8_W      = BINW_W + 8;
    localparam int DVD_W      = HEIGHT_W + WQ8_W;
    localparam int DCNT_W     = $clog2(DVD_W + 1);
    localparam int TERM_W     = HEIGHT_W + 1 + WQ8_W - 9;
    localparam int QDEPTH     = 2;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int CIDX_W     = 2;

    localparam logic [SHARE_W-1:0] MIN_SHARE = 16'd65;
    localparam logic [SHARE_W-1:0] SHARE_MAX = 16'hFFFF;

    localparam logic [CIDX_W-1:0] CFG_CUT_LEVEL   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BIN_WIDTH   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_START_YEAR  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_SHARE_SCALE = 2'd3;

    localparam logic KIND_RANGE = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    typedef struct packed {
        logic [HEIGHT_W-1:0] cut_level;
        logic [BINW_W-1:0]   bin_width;
        logic [YEAR_W-1:0]   start_year;
        logic [SCALE_W-1:0]  share_scale;
    } cfg_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                final_sample;
        logic                above;
    } item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } q_status_t;

    typedef struct packed {
        logic                start;
        logic [HEIGHT_W-1:0] num;
        logic [WQ8_W-1:0]    w;
        logic [HEIGHT_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [WQ8_W-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic                     kind;
        logic signed [POS_W-1:0]  range_begin;
        logic signed [POS_W-1:0]  range_finish;
        logic [SHARE_W-1:0]       share;
        logic                     closing;
    } res_t;

endpackage
`default_nettype wire

@@ hdl/dcors_front.sv @@
// Front part: accepts samples, marks them against the cut level and queues them.
`default_nettype none
module dcors_front (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              samp_valid,
    output logic                             samp_stall,
    input  wire  [dcors_pkg::HEIGHT_W-1:0]   height,
    input  wire                              final_sample,
    input  wire  [dcors_pkg::HEIGHT_W-1:0]   cut_level,
    input  wire                              pop,
    output logic                             q_valid,
    output dcors_pkg::item_t                 q_item,
    output dcors_pkg::q_status_t             q_status
);
    import dcors_pkg::*;

    item_t             entry_reg [QDEPTH];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push, do_pop;

    assign samp_stall = (cnt_reg == QCNT_W'(QDEPTH));
    assign push       = samp_valid && !samp_stall;
    assign q_valid    = (cnt_reg != '0);
    assign do_pop     = pop && q_valid;
    assign q_item     = entry_reg[rd_ptr_reg];
    assign q_status.count = cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg].height       <= height;
            entry_reg[wr_ptr_reg].final_sample <= final_sample;
            entry_reg[wr_ptr_reg].above        <= (height > cut_level);
        end
    end

endmodule
`default_nettype wire

@@ hdl/dcors_div.sv @@
// Bit-serial restoring divider that places a crossing inside its bin.
`default_nettype none
module dcors_div (
    input  wire                  clk,
    input  wire                  rst_n,
    input  dcors_pkg::div_req_t  req,
    output dcors_pkg::div_rsp_t  rsp
);
    import dcors_pkg::*;

    logic [DVD_W-1:0]    dvd_reg;
    logic [HEIGHT_W-1:0] rem_reg;
    logic [HEIGHT_W-1:0] den_reg;
    logic [DCNT_W-1:0]   cnt_reg;
    logic                busy_reg, done_reg;
    logic [HEIGHT_W:0]   trial;
    logic                fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    assign rsp.done = done_reg;
    assign rsp.quo  = dvd_reg[WQ8_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= DVD_W'(req.num * req.w);
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? HEIGHT_W'(trial - {1'b0, den_reg}) : trial[HEIGHT_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
        end
    end

endmodule
`default_nettype wire

@@ hdl/dcors_back.sv @@
// Back part: sequencer that integrates areas, closes ranges and emits results.
`default_nettype none
module dcors_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  dcors_pkg::cfg_t      cfg,
    input  wire                  q_valid,
    input  dcors_pkg::item_t     q_item,
    output logic                 pop,
    output dcors_pkg::div_req_t  div_req,
    input  dcors_pkg::div_rsp_t  div_rsp,
    output logic                 res_valid,
    input  wire                  res_stall,
    output dcors_pkg::res_t      res
);
    import dcors_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_POS    = 4'd1;
    localparam logic [3:0] S_DSTART = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_AREA   = 4'd4;
    localparam logic [3:0] S_ADD    = 4'd5;
    localparam logic [3:0] S_SH1    = 4'd6;
    localparam logic [3:0] S_SH2    = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;
    localparam logic [3:0] S_TOT    = 4'd10;

    localparam logic [1:0] MODE_OPEN  = 2'd0;
    localparam logic [1:0] MODE_MID   = 2'd1;
    localparam logic [1:0] MODE_CLOSE = 2'd2;

    logic [3:0]          state_reg;
    logic [HEIGHT_W-1:0] h_reg, prev_reg, num_reg, den_reg;
    logic                fin_reg, above_reg, inside_reg, cfin_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [POS_W-1:0]    obeg_reg, x0_reg, fpos_reg;
    logic [AREA_W-1:0]   area_reg;
    logic [SHARE_W-1:0]  tot_reg, sh_reg;
    logic [WQ8_W-1:0]    dx_reg;
    logic [1:0]          mode_reg;
    logic [TERM_W-1:0]   term_reg;
    logic [63:0]         plo_reg;
    logic [47:0]         phi_reg;
    logic                rvalid_reg;
    res_t                res_reg;

    logic [WQ8_W-1:0]    w;
    logic [POS_W-1:0]    base_pos, pos_km1;
    logic [IDX_W-1:0]    km1;
    logic [27:0]         kb;
    logic [HEIGHT_W:0]   ma;
    logic [WQ8_W-1:0]    mb;
    logic [HEIGHT_W+WQ8_W:0] prod;
    logic [AREA_W:0]     asum;
    logic [48:0]         shv;
    logic [SHARE_W-1:0]  sh_sat;
    logic [SHARE_W:0]    tsum;
    logic                out_free;
    logic                emit;
    logic [HEIGHT_W-1:0] c;

    assign c        = cfg.cut_level;
    assign w        = {cfg.bin_width, 8'd0};
    assign base_pos = {{(POS_W - YEAR_W - 8){cfg.start_year[YEAR_W-1]}}, cfg.start_year, 8'd0};
    assign km1      = idx_reg - 1'b1;
    assign kb       = 28'(km1 * cfg.bin_width);
    assign pos_km1  = base_pos + {kb[23:0], 8'd0};
    assign out_free = !rvalid_reg || !res_stall;
    assign emit     = ((state_reg == S_EMIT) || (state_reg == S_TOT)) && out_free;
    assign pop      = (state_reg == S_IDLE) && q_valid;

    assign div_req.start = (state_reg == S_DSTART);
    assign div_req.num   = num_reg;
    assign div_req.w     = w;
    assign div_req.den   = den_reg;

    assign res_valid = rvalid_reg;
    assign res       = res_reg;

    always_comb
    begin
        case (mode_reg)
            MODE_OPEN:
            begin
                ma = {1'b0, c} + {1'b0, h_reg};
                mb = w - dx_reg;
            end
            MODE_MID:
            begin
                ma = {1'b0, prev_reg} + {1'b0, h_reg};
                mb = w;
            end
            default:
            begin
                ma = {1'b0, prev_reg} + {1'b0, c};
                mb = dx_reg;
            end
        endcase
    end

    assign prod   = ma * mb;
    assign asum   = {1'b0, (mode_reg == MODE_OPEN) ? {AREA_W{1'b0}} : area_reg}
                    + (AREA_W + 1)'(term_reg);
    assign shv    = {1'b0, phi_reg} + 49'(plo_reg[63:32]);
    assign sh_sat = (shv > 49'(SHARE_MAX)) ? SHARE_MAX : shv[SHARE_W-1:0];
    assign tsum   = {1'b0, tot_reg} + {1'b0, sh_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            prev_reg   <= '0;
            idx_reg    <= '0;
            inside_reg <= 1'b0;
            obeg_reg   <= '0;
            area_reg   <= '0;
            tot_reg    <= '0;
            rvalid_reg <= 1'b0;
            cfin_reg   <= 1'b0;
            mode_reg   <= MODE_OPEN;
            dx_reg     <= '0;
        end
        else
        begin
            if (emit)
            begin
                rvalid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                rvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= S_POS;
                    end
                end
                S_POS:
                begin
                    if (idx_reg >= IDX_W'(MAX_BINS))
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (idx_reg == '0)
                    begin
                        area_reg   <= '0;
                        inside_reg <= above_reg;
                        if (above_reg)
                        begin
                            obeg_reg <= base_pos;
                        end
                        prev_reg  <= h_reg;
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_FIN;
                    end
                    else if (!inside_reg)
                    begin
                        if (above_reg)
                        begin
                            mode_reg <= MODE_OPEN;
                            if (c >= prev_reg)
                            begin
                                state_reg <= S_DSTART;
                            end
                            else
                            begin
                                dx_reg    <= '0;
                                state_reg <= S_AREA;
                            end
                        end
                        else
                        begin
                            prev_reg  <= h_reg;
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_FIN;
                        end
                    end
                    else if (above_reg)
                    begin
                        mode_reg  <= MODE_MID;
                        state_reg <= S_AREA;
                    end
                    else
                    begin
                        mode_reg <= MODE_CLOSE;
                        if (prev_reg > c)
                        begin
                            state_reg <= S_DSTART;
                        end
                        else
                        begin
                            dx_reg    <= '0;
                            state_reg <= S_AREA;
                        end
                    end
                end
                S_DSTART:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        dx_reg    <= div_rsp.quo;
                        state_reg <= S_AREA;
                    end
                end
                S_AREA:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    area_reg <= asum[AREA_W] ? '1 : asum[AREA_W-1:0];
                    if (mode_reg == MODE_OPEN)
                    begin
                        obeg_reg   <= x0_reg + POS_W'(dx_reg);
                        inside_reg <= 1'b1;
                    end
                    prev_reg <= h_reg;
                    idx_reg  <= idx_reg + 1'b1;
                    if (mode_reg == MODE_CLOSE)
                    begin
                        cfin_reg  <= 1'b0;
                        state_reg <= S_SH1;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_SH1:
                begin
                    state_reg <= S_SH2;
                end
                S_SH2:
                begin
                    area_reg   <= '0;
                    inside_reg <= 1'b0;
                    if (sh_sat > MIN_SHARE)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= cfin_reg ? S_TOT : S_FIN;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        tot_reg    <= tsum[SHARE_W] ? SHARE_MAX : tsum[SHARE_W-1:0];
                        state_reg  <= cfin_reg ? S_TOT : S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!fin_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (inside_reg && (idx_reg >= IDX_W'(2)))
                    begin
                        cfin_reg  <= 1'b1;
                        state_reg <= S_SH1;
                    end
                    else
                    begin
                        state_reg <= S_TOT;
                    end
                end
                S_TOT:
                begin
                    if (out_free)
                    begin
                        prev_reg   <= '0;
                        idx_reg    <= '0;
                        inside_reg <= 1'b0;
                        obeg_reg   <= '0;
                        area_reg   <= '0;
                        tot_reg    <= '0;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            h_reg     <= q_item.height;
            fin_reg   <= q_item.final_sample;
            above_reg <= q_item.above;
        end
        if (state_reg == S_POS)
        begin
            x0_reg <= pos_km1;
            if (inside_reg)
            begin
                num_reg <= prev_reg - c;
                den_reg <= prev_reg - h_reg;
            end
            else
            begin
                num_reg <= c - prev_reg;
                den_reg <= h_reg - prev_reg;
            end
        end
        if (state_reg == S_AREA)
        begin
            term_reg <= prod[HEIGHT_W+WQ8_W:9];
        end
        if (state_reg == S_ADD)
        begin
            fpos_reg <= x0_reg + POS_W'(dx_reg);
        end
        if (state_reg == S_FIN)
        begin
            fpos_reg <= pos_km1;
        end
        if (state_reg == S_SH1)
        begin
            plo_reg <= area_reg[31:0] * cfg.share_scale;
            phi_reg <= area_reg[47:32] * cfg.share_scale;
        end
        if (state_reg == S_SH2)
        begin
            sh_reg <= sh_sat;
        end
        if (state_reg == S_EMIT && out_free)
        begin
            res_reg.kind         <= KIND_RANGE;
            res_reg.range_begin  <= obeg_reg;
            res_reg.range_finish <= fpos_reg;
            res_reg.share        <= sh_reg;
            res_reg.closing      <= 1'b0;
        end
        if (state_reg == S_TOT && out_free)
        begin
            res_reg.kind         <= KIND_TOTAL;
            res_reg.range_begin  <= '0;
            res_reg.range_finish <= '0;
            res_reg.share        <= tot_reg;
            res_reg.closing      <= 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ hdl/density_cut_off_range_scan.sv @@
// Top level of the density cut-off range scan: config registers, front, back, divider.
`default_nettype none
// Feeds one sample of a binned probability curve per transaction on the samp
// channel and reports, on the res channel, every range where the curve stays
// above cut_level with a share of more than 65/65536, followed after the
// sample marked final_sample by one total-share transaction with closing set.
// A two-entry queue takes samples while the back sequencer works, so the samp
// side only stalls when both entries are full. The sequencer passes S_IDLE,
// S_POS and S_FIN for a sample that stays at or below the level, adds S_AREA
// and S_ADD for one that stays above it or opens a range without a division,
// and adds S_DSTART and S_DIV for a crossing that needs the bit-serial
// crossing divider, waiting there for its 35 quotient bits (one per cycle).
// Closing a range adds S_SH1 and S_SH2 for the share multiply and, when the
// range is reported, S_EMIT for its transaction; the total-share transaction
// after the final sample takes S_TOT. Configuration writes are always ready
// and should be made only while the block is idle.
module density_cut_off_range_scan (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   samp_valid,
    output logic                                  samp_stall,
    input  wire  [dcors_pkg::HEIGHT_W-1:0]        height,
    input  wire                                   final_sample,
    output logic                                  res_valid,
    input  wire                                   res_stall,
    output logic                                  kind,
    output logic signed [dcors_pkg::POS_W-1:0]    range_begin,
    output logic signed [dcors_pkg::POS_W-1:0]    range_finish,
    output logic [dcors_pkg::SHARE_W-1:0]         share,
    output logic                                  closing,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [dcors_pkg::CIDX_W-1:0]          cfg_index,
    input  wire  [31:0]                           cfg_data
);
    import dcors_pkg::*;

    cfg_t      cfg_reg;
    item_t     q_item;
    q_status_t q_status;
    div_req_t  div_req;
    div_rsp_t  div_rsp;
    res_t      res;
    logic      q_valid, pop;

    // The register file never holds off a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cut_level   <= 16'd32768;
            cfg_reg.bin_width   <= 11'd1;
            cfg_reg.start_year  <= '0;
            cfg_reg.share_scale <= 32'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CUT_LEVEL:   cfg_reg.cut_level   <= cfg_data[HEIGHT_W-1:0];
                CFG_BIN_WIDTH:   cfg_reg.bin_width   <= cfg_data[BINW_W-1:0];
                CFG_START_YEAR:  cfg_reg.start_year  <= cfg_data[YEAR_W-1:0];
                CFG_SHARE_SCALE: cfg_reg.share_scale <= cfg_data[SCALE_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Front: accepts each transaction and marks it against the cut level.
    dcors_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .samp_valid   (samp_valid),
        .samp_stall   (samp_stall),
        .height       (height),
        .final_sample (final_sample),
        .cut_level    (cfg_reg.cut_level),
        .pop          (pop),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_status     (q_status)
    );

    // Back: integrates, closes ranges and drives the result register.
    dcors_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // Divider used for the interpolated crossing offset.
    dcors_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign kind         = res.kind;
    assign range_begin  = res.range_begin;
    assign range_finish = res.range_finish;
    assign share        = res.share;
    assign closing      = res.closing;

    // Only the total-share transaction closes a run.
    a_closing_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (closing == kind))
        else $error("closing flag does not match result kind");

    // A reported range always exceeds the minimum share.
    a_range_share: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (kind == KIND_RANGE)) |-> (share > MIN_SHARE))
        else $error("range reported below minimum share");

    // The sample queue never holds more than its depth.
    a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QCNT_W'(QDEPTH))
        else $error("sample queue overfilled");

    // A total-share transaction carries no range position.
    a_total_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (kind == KIND_TOTAL)) |-> ((range_begin == '0) && (range_finish == '0)))
        else $error("total share carries a position");

endmodule
`default_nettype wire

@@ tb/sv/dcors_scoreboard.sv @@
// Checker of the density cut-off range scan: predicts every result and compares it.
`default_nettype none
module dcors_scoreboard
    import dcors_pkg::*;
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        samp_valid,
    input  wire                        samp_stall,
    input  wire  [HEIGHT_W-1:0]        height,
    input  wire                        final_sample,
    input  wire                        res_valid,
    input  wire                        res_stall,
    input  wire                        kind,
    input  wire  signed [POS_W-1:0]    range_begin,
    input  wire  signed [POS_W-1:0]    range_finish,
    input  wire  [SHARE_W-1:0]         share,
    input  wire                        closing,
    input  wire                        cfg_valid,
    input  wire                        cfg_ready,
    input  wire  [CIDX_W-1:0]          cfg_index,
    input  wire  [31:0]                cfg_data,
    output int                         fail_count,
    output int                         pending
);

    localparam logic [63:0] AREA_SAT = (64'd1 << AREA_W) - 64'd1;

    // Shadow copy of the registers.
    logic [HEIGHT_W-1:0] cut;
    logic [BINW_W-1:0]   bw;
    logic [YEAR_W-1:0]   first_year;
    logic [SCALE_W-1:0]  scale;

    // Shadow copy of the run state.
    logic [HEIGHT_W-1:0] last_height;
    int                  bins_taken;
    logic                in_range;
    logic [POS_W-1:0]    range_start;
    logic [63:0]         area;
    int                  share_sum;

    res_t                expected_results[$];

    assign pending = expected_results.size();

    function automatic logic [63:0] year_pos(input logic [63:0] k);
        logic [63:0] s;
        logic [63:0] wq;
        s  = {{47{first_year[YEAR_W-1]}}, first_year};
        wq = bw;
        return (s << 8) + k * (wq << 8);
    endfunction

    function automatic logic [63:0] area_share(input logic [63:0] a);
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] sc;
        logic [63:0] v;
        hi = a >> 32;
        lo = a & 64'hFFFF_FFFF;
        sc = scale;
        v  = hi * sc + ((lo * sc) >> 32);
        return (v > 64'd65535) ? 64'd65535 : v;
    endfunction

    task automatic add_area(input logic [63:0] t);
        area = area + t;
        if (area > AREA_SAT)
            area = AREA_SAT;
    endtask

    task automatic close_range(input logic [63:0] finish);
        logic [63:0] sh;
        res_t        r;
        sh       = area_share(area);
        area     = 0;
        in_range = 1'b0;
        if (sh > 64'(MIN_SHARE))
        begin
            r.kind           = KIND_RANGE;
            r.range_begin    = range_start;
            r.range_finish   = finish[POS_W-1:0];
            r.share          = sh[SHARE_W-1:0];
            r.closing        = 1'b0;
            expected_results = {expected_results, r};
            share_sum        = share_sum + int'(sh);
            if (share_sum > 65535)
                share_sum = 65535;
        end
    endtask

    task automatic clear_run();
        last_height = 0;
        bins_taken  = 0;
        in_range    = 1'b0;
        range_start = 0;
        area        = 0;
        share_sum   = 0;
    endtask

    task automatic predict_sample(input logic [HEIGHT_W-1:0] h, input logic fin);
        logic [63:0] c;
        logic [63:0] y1;
        logic [63:0] y2;
        logic [63:0] w;
        logic [63:0] x0;
        logic [63:0] dx;
        logic [63:0] pos;
        res_t        r;
        c = cut;
        if (bins_taken < MAX_BINS)
        begin
            if (bins_taken == 0)
            begin
                area = 0;
                if (h > c)
                begin
                    in_range    = 1'b1;
                    pos         = year_pos(0);
                    range_start = pos[POS_W-1:0];
                end
                else
                begin
                    in_range = 1'b0;
                end
            end
            else
            begin
                y1 = last_height;
                y2 = h;
                w  = bw;
                w  = w << 8;
                x0 = year_pos(bins_taken - 1);
                if (!in_range)
                begin
                    if (y2 > c)
                    begin
                        dx          = (c >= y1) ? w * (c - y1) / (y2 - y1) : 64'd0;
                        pos         = x0 + dx;
                        range_start = pos[POS_W-1:0];
                        area        = 0;
                        add_area(((c + y2) * (w - dx)) >> 9);
                        in_range    = 1'b1;
                    end
                end
                else if (y2 > c)
                begin
                    add_area(((y1 + y2) * w) >> 9);
                end
                else
                begin
                    dx = (y1 > c) ? w * (y1 - c) / (y1 - y2) : 64'd0;
                    add_area(((y1 + c) * dx) >> 9);
                    close_range(x0 + dx);
                end
            end
            last_height = h;
            bins_taken  = bins_taken + 1;
        end
        if (fin)
        begin
            if (in_range && bins_taken >= 2)
                close_range(year_pos(bins_taken - 1));
            r.kind           = KIND_TOTAL;
            r.range_begin    = 0;
            r.range_finish   = 0;
            r.share          = share_sum[SHARE_W-1:0];
            r.closing        = 1'b1;
            expected_results = {expected_results, r};
            clear_run();
        end
    endtask

    task automatic check_result();
        res_t want;
        if (expected_results.size() == 0)
        begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
                $display("ERROR: unexpected result kind=%0d begin=%0d finish=%0d %s",
                         kind, range_begin, range_finish,
                         $sformatf("share=%0d closing=%0d", share, closing));
        end
        else
        begin
            want = expected_results.pop_front();
            if (want.kind !== kind || want.range_begin !== range_begin ||
                want.range_finish !== range_finish || want.share !== share ||
                want.closing !== closing)
            begin
                fail_count = fail_count + 1;
                if (fail_count <= 10)
                begin
                    $display("ERROR: expected kind=%0d begin=%0d finish=%0d share=%0d closing=%0d",
                             want.kind, want.range_begin, want.range_finish, want.share,
                             want.closing);
                    $display("       got      kind=%0d begin=%0d finish=%0d share=%0d closing=%0d",
                             kind, range_begin, range_finish, share, closing);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut        = 16'd32768;
            bw         = 11'd1;
            first_year = 0;
            scale      = 32'd65536;
            clear_run();
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CUT_LEVEL:   cut        = cfg_data[HEIGHT_W-1:0];
                    CFG_BIN_WIDTH:   bw         = cfg_data[BINW_W-1:0];
                    CFG_START_YEAR:  first_year = cfg_data[YEAR_W-1:0];
                    CFG_SHARE_SCALE: scale      = cfg_data[SCALE_W-1:0];
                    default:         ;
                endcase
            end
            if (samp_valid && !samp_stall)
                predict_sample(height, final_sample);
            if (res_valid && !res_stall)
                check_result();
        end
    end

endmodule
`default_nettype wire

@@ tb/sv/tb_density_cut_off_range_scan.sv @@
// Testbench top of the density cut-off range scan: stimulus, clock, reset and verdict.
`default_nettype none
module tb_density_cut_off_range_scan;
    import dcors_pkg::*;

    // Cycles with no transaction on any channel before the run is declared hung.
    localparam int HANG_LIMIT = 3000;
    // Quiet cycles allowed for samples still in flight that cause no result.
    localparam int DRAIN_CYCLES = 150;
    // Samples sent in each random phase, at least.
    localparam int PHASE_SAMPLES = 60;

    logic                      clk;
    logic                      rst_n;
    logic                      samp_valid;
    logic                      samp_stall;
    logic [HEIGHT_W-1:0]       height;
    logic                      final_sample;
    logic                      res_valid;
    logic                      res_stall;
    logic                      kind;
    logic signed [POS_W-1:0]   range_begin;
    logic signed [POS_W-1:0]   range_finish;
    logic [SHARE_W-1:0]        share;
    logic                      closing;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CIDX_W-1:0]         cfg_index;
    logic [31:0]               cfg_data;

    int fail_count;
    int pending;
    int sender_idle_pct;
    int receiver_stall_pct;
    int samples_sent;
    int quiet_cycles;

    density_cut_off_range_scan u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .samp_valid   (samp_valid),
        .samp_stall   (samp_stall),
        .height       (height),
        .final_sample (final_sample),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .kind         (kind),
        .range_begin  (range_begin),
        .range_finish (range_finish),
        .share        (share),
        .closing      (closing),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // The checker sees exactly what the block sees and predicts on its own.
    dcors_scoreboard u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .samp_valid   (samp_valid),
        .samp_stall   (samp_stall),
        .height       (height),
        .final_sample (final_sample),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .kind         (kind),
        .range_begin  (range_begin),
        .range_finish (range_finish),
        .share        (share),
        .closing      (closing),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The result side stalls at random, one decision per cycle, at the rate
    // that the current phase sets.
    always @(posedge clk)
    begin
        res_stall <= (receiver_stall_pct > 0) && ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // Watchdog: any accepted transaction on any channel resets the count.
    always @(posedge clk)
    begin
        if ((samp_valid && !samp_stall) || (res_valid && !res_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("ERROR: no transaction for %0d cycles", HANG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Idling profiles: none, sender only, receiver only, or both lightly.
    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            1:
            begin
                sender_idle_pct    = 74;
                receiver_stall_pct = 0;
            end
            2:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 74;
            end
            default:
            begin
                sender_idle_pct    = 20;
                receiver_stall_pct = 20;
            end
        endcase
    endtask

    // Offers one sample and returns at the edge where the block takes it. The
    // stall is looked at on the falling edge, where it is settled, and the
    // transaction completes on the rising edge that follows if it was low.
    task automatic send_sample(input logic [HEIGHT_W-1:0] h, input logic fin);
        logic stalled;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            samp_valid <= 1'b0;
            @(posedge clk);
        end
        samp_valid   <= 1'b1;
        height       <= h;
        final_sample <= fin;
        do
        begin
            @(negedge clk);
            stalled = samp_stall;
            @(posedge clk);
        end
        while (stalled);
        samples_sent = samples_sent + 1;
    endtask

    // Drops the sample valid, waits until every predicted result has arrived,
    // then lets the crossing divider and the sample queue run dry.
    task automatic wait_quiet();
        samp_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; only called once the block has gone quiet.
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [31:0] value);
        logic ready_seen;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            ready_seen = cfg_ready;
            @(posedge clk);
        end
        while (!ready_seen);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] cut, input logic [10:0] bw,
                             input logic [16:0] year, input logic [31:0] scale);
        write_reg(CFG_CUT_LEVEL, {16'd0, cut});
        write_reg(CFG_BIN_WIDTH, {21'd0, bw});
        write_reg(CFG_START_YEAR, {15'd0, year});
        write_reg(CFG_SHARE_SCALE, scale);
    endtask

    // A random curve: mostly a random walk, so that the curve rises and falls
    // through the cut level in runs, with an occasional jump anywhere. About
    // one curve in ten is pure noise, where a stray final may end it early.
    task automatic random_curve(input int n);
        int  level;
        int  step;
        bit  noisy;
        logic fin;
        noisy = ($urandom_range(0, 9) == 0);
        level = $urandom_range(0, 65535);
        for (int i = 0; i < n; i++)
        begin
            if (noisy || $urandom_range(0, 7) == 0)
            begin
                level = $urandom_range(0, 65535);
            end
            else
            begin
                step  = int'($urandom_range(0, 16000)) - 8000;
                level = level + step;
                if (level < 0)
                    level = 0;
                if (level > 65535)
                    level = 65535;
            end
            fin = (i == n - 1) || (noisy && $urandom_range(0, 5) == 0);
            send_sample(level[15:0], fin);
        end
    endtask

    initial
    begin
        int phase_start;
        logic [15:0] cut;
        logic [10:0] bw;
        logic [16:0] year;
        logic [31:0] scale;

        rst_n        <= 1'b0;
        samp_valid   <= 1'b0;
        height       <= '0;
        final_sample <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        samples_sent = 0;
        set_idling(0);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A large scale lets even small areas report a range.
        write_all(16'd32768, 11'd4, 17'h10000, 32'hFFFF_FFFF);
        // A single sample gives no range, only a zero total.
        send_sample(16'hFFFF, 1'b1);
        // A curve that starts above the level and falls in its first bin.
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b1);
        // A range still open at the last sample closes there.
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b1);

        // The level moves in the middle of a run, with the run kept open:
        // first while inside a range, then while outside one.
        wait_quiet();
        write_reg(CFG_CUT_LEVEL, 32'd30000);
        send_sample(16'd10000, 1'b0);
        send_sample(16'd40000, 1'b0);
        wait_quiet();
        write_reg(CFG_CUT_LEVEL, 32'd50000);
        send_sample(16'd20000, 1'b0);
        send_sample(16'd40000, 1'b0);
        wait_quiet();
        write_reg(CFG_CUT_LEVEL, 32'd30000);
        send_sample(16'd45000, 1'b0);
        send_sample(16'd0, 1'b1);

        // Zero bin width: positions stand still and the areas vanish.
        wait_quiet();
        write_all(16'd0, 11'd0, 17'h0FFFF, 32'd0);
        send_sample(16'd0, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd0, 1'b1);

        // Bins of width 1024 from the last year; then the highest level,
        // which nothing can exceed.
        wait_quiet();
        write_all(16'd1, 11'd1024, 17'h0FFFF, 32'hFFFF_FFFF);
        send_sample(16'd0, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd0, 1'b1);
        wait_quiet();
        write_reg(CFG_CUT_LEVEL, 32'd65535);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b1);

        // Random part, in phases that each change every register and the
        // idling profile; the first phases pin the register extremes.
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_quiet();
            set_idling(ph % 4);
            cut   = (ph == 0) ? 16'd0 : (ph == 1) ? 16'd65535 : 16'($urandom_range(10000, 55000));
            bw    = (ph == 2) ? 11'd1024 : (ph == 3) ? 11'd1 : 11'($urandom_range(1, 16));
            year  = (ph == 4) ? 17'h10000 : (ph == 5) ? 17'h0FFFF : 17'($urandom);
            scale = (ph == 6) ? 32'd0 : (ph == 7) ? 32'hFFFF_FFFF : $urandom;
            write_all(cut, bw, year, scale);
            phase_start = samples_sent;
            while (samples_sent - phase_start < PHASE_SAMPLES)
                random_curve($urandom_range(1, 20));
        end

        wait_quiet();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
hdl/dcors_pkg.sv
hdl/dcors_front.sv
hdl/dcors_div.sv
hdl/dcors_back.sv
hdl/density_cut_off_range_scan.sv
tb/sv/dcors_scoreboard.sv
tb/sv/tb_density_cut_off_range_scan.sv
